// ===== hdl/chsgeo_pkg.sv =====
// Package for the CHS geometry inference block.
// Holds table sizes, entry and job types and the CHS field helpers.
// Used by every module in this folder except chsgeo_div; depends on nothing.
package chsgeo_pkg;

  localparam int TABLE_ENTRIES = 4;
  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  localparam logic [7:0] SECT_MASK = 8'h3F;
  localparam logic [7:0] CYLH_MASK = 8'hC0;

  typedef struct packed {
    logic [47:0] chs;
    logic [31:0] offset;
    logic [31:0] size;
  } entry_t;

  typedef struct packed {
    entry_t [TABLE_ENTRIES-1:0] ent;
    logic [CNT_W-1:0]           count;
  } job_t;

  function automatic logic [7:0] chs_byte(input logic [47:0] chs, input int unsigned k);
    chs_byte = chs[8*k +: 8];
  endfunction

  // The end flag selects the ending triple, otherwise the starting one.
  function automatic logic [31:0] t_head(input logic [47:0] chs, input logic end_t);
    t_head = {24'd0, chs_byte(chs, end_t ? 3 : 0)};
  endfunction

  function automatic logic [31:0] t_sect(input logic [47:0] chs, input logic end_t);
    t_sect = {24'd0, chs_byte(chs, end_t ? 4 : 1) & SECT_MASK};
  endfunction

  function automatic logic [31:0] t_cylb(input logic [47:0] chs, input logic end_t);
    t_cylb = {24'd0, chs_byte(chs, end_t ? 5 : 2)};
  endfunction

  function automatic logic [31:0] t_cyl(input logic [47:0] chs, input logic end_t);
    logic [7:0] hi;
    hi = chs_byte(chs, end_t ? 4 : 1) & CYLH_MASK;
    t_cyl = t_cylb(chs, end_t) | {22'd0, hi, 2'd0};
  endfunction

endpackage

// ===== hdl/chs_geometry_inference.sv =====
// Top level of the CHS geometry inference block: front, job queue and engine.
// Depends on chsgeo_pkg, chsgeo_front, chsgeo_queue and chsgeo_back.
// Entries are taken one per cycle while the queue is not full; a table waits in a two-deep queue.
// The time from the last entry to the result is set by the runs of the shared serial
// divider and the three-step linear checks.
// Synchronous active-low reset empties the table, the queue and the output.
module chs_geometry_inference (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_start_head,
  input  logic [7:0]  in_start_sector_byte,
  input  logic [7:0]  in_start_cyl_low,
  input  logic [7:0]  in_end_head,
  input  logic [7:0]  in_end_sector_byte,
  input  logic [7:0]  in_end_cyl_low,
  input  logic [31:0] in_lba_offset,
  input  logic [31:0] in_lba_size,
  input  logic        in_last_entry,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_found,
  output logic        out_method_used,
  output logic [31:0] out_heads,
  output logic [31:0] out_sectors_per_track,
  output logic [31:0] out_cylinder_blocks
);

  logic             q_full, q_push, q_empty, q_pop;
  chsgeo_pkg::job_t q_wdata, q_rdata;

  chsgeo_front u_front (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_start_head        (in_start_head),
    .in_start_sector_byte (in_start_sector_byte),
    .in_start_cyl_low     (in_start_cyl_low),
    .in_end_head          (in_end_head),
    .in_end_sector_byte   (in_end_sector_byte),
    .in_end_cyl_low       (in_end_cyl_low),
    .in_lba_offset        (in_lba_offset),
    .in_lba_size          (in_lba_size),
    .in_last_entry        (in_last_entry),
    .q_full               (q_full),
    .q_push               (q_push),
    .q_data               (q_wdata)
  );

  chsgeo_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wdata),
    .full      (q_full),
    .pop       (q_pop),
    .empty     (q_empty),
    .pop_data  (q_rdata)
  );

  chsgeo_back u_back (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .q_empty               (q_empty),
    .q_pop                 (q_pop),
    .q_data                (q_rdata),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_found             (out_found),
    .out_method_used       (out_method_used),
    .out_heads             (out_heads),
    .out_sectors_per_track (out_sectors_per_track),
    .out_cylinder_blocks   (out_cylinder_blocks)
  );

endmodule

// ===== hdl/chsgeo_front.sv =====
// Front part: accepts partition entries and collects them into a table.
// On the last entry it hands the whole table as one job to the queue.
// Depends on chsgeo_pkg.
module chsgeo_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [7:0]          in_start_head,
  input  logic [7:0]          in_start_sector_byte,
  input  logic [7:0]          in_start_cyl_low,
  input  logic [7:0]          in_end_head,
  input  logic [7:0]          in_end_sector_byte,
  input  logic [7:0]          in_end_cyl_low,
  input  logic [31:0]         in_lba_offset,
  input  logic [31:0]         in_lba_size,
  input  logic                in_last_entry,
  input  logic                q_full,
  output logic                q_push,
  output chsgeo_pkg::job_t    q_data
);

  chsgeo_pkg::entry_t [chsgeo_pkg::TABLE_ENTRIES-1:0] tab_r, tab_nxt;
  logic [chsgeo_pkg::CNT_W-1:0] cnt_r, cnt_nxt;
  logic                         acc;
  chsgeo_pkg::entry_t           new_ent;

  assign in_stall = q_full;
  assign acc      = in_valid && !in_stall;

  always_comb begin
    new_ent.chs    = {in_end_cyl_low, in_end_sector_byte, in_end_head,
                      in_start_cyl_low, in_start_sector_byte, in_start_head};
    new_ent.offset = in_lba_offset;
    new_ent.size   = in_lba_size;
    tab_nxt = tab_r;
    cnt_nxt = cnt_r;
    if (acc && (cnt_r < chsgeo_pkg::CNT_W'(chsgeo_pkg::TABLE_ENTRIES))) begin
      tab_nxt[cnt_r[chsgeo_pkg::IDX_W-1:0]] = new_ent;
      cnt_nxt = cnt_r + 1'b1;
    end
    q_push       = acc && in_last_entry;
    q_data.ent   = tab_nxt;
    q_data.count = cnt_nxt;
    if (q_push) begin
      cnt_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    tab_r <= tab_nxt;
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

endmodule

// ===== hdl/chsgeo_queue.sv =====
// Short job queue between the front and the back part.
// Holds complete tables waiting for the geometry engine.
// Depends on chsgeo_pkg.
module chsgeo_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  chsgeo_pkg::job_t push_data,
  output logic             full,
  input  logic             pop,
  output logic             empty,
  output chsgeo_pkg::job_t pop_data
);

  chsgeo_pkg::job_t mem_r [chsgeo_pkg::QUEUE_DEPTH];
  logic [chsgeo_pkg::QPTR_W-1:0] wp_r, rp_r;
  logic [chsgeo_pkg::QCNT_W-1:0] cnt_r;

  assign full     = (cnt_r == chsgeo_pkg::QCNT_W'(chsgeo_pkg::QUEUE_DEPTH));
  assign empty    = (cnt_r == '0);
  assign pop_data = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= push_data;
    end
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= wp_r + 1'b1;
      end
      if (pop) begin
        rp_r <= rp_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

// ===== hdl/chsgeo_div.sv =====
// Restoring divider, one quotient bit per cycle, for 32-bit unsigned values.
// Gives quotient and remainder with a one-cycle done pulse.
// Depends on chsgeo_pkg only through the project conventions.
module chsgeo_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [31:0] divisor,
  output logic        done,
  output logic [31:0] quo,
  output logic [31:0] rem
);

  logic [31:0] q_r, d_r;
  logic [32:0] r_r;
  logic [5:0]  cnt_r;
  logic        busy_r, done_r;
  logic [32:0] sh;
  logic        ge;

  assign sh   = {r_r[31:0], q_r[31]};
  assign ge   = (sh >= {1'b0, d_r});
  assign done = done_r;
  assign quo  = q_r;
  assign rem  = r_r[31:0];

  always_ff @(posedge clk) begin
    if (start) begin
      q_r <= dividend;
      d_r <= divisor;
      r_r <= '0;
    end else if (busy_r) begin
      q_r <= {q_r[30:0], ge};
      r_r <= ge ? (sh - {1'b0, d_r}) : sh;
    end
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= 6'd32;
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == 6'd1) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== hdl/chsgeo_back.sv =====
// Back part: sequencer that runs the equation method and the heuristic
// over one table, sharing one multiplier and the serial divider.
// Depends on chsgeo_pkg and chsgeo_div.
module chsgeo_back (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             q_empty,
  output logic             q_pop,
  input  chsgeo_pkg::job_t q_data,
  output logic             out_valid,
  input  logic             out_stall,
  output logic             out_found,
  output logic             out_method_used,
  output logic [31:0]      out_heads,
  output logic [31:0]      out_sectors_per_track,
  output logic [31:0]      out_cylinder_blocks
);

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_ECS   = 5'd1;
  localparam logic [4:0] S_CM0   = 5'd2;
  localparam logic [4:0] S_CM1   = 5'd3;
  localparam logic [4:0] S_CM2   = 5'd4;
  localparam logic [4:0] S_CM3   = 5'd5;
  localparam logic [4:0] S_CPREP = 5'd6;
  localparam logic [4:0] S_CWAIT = 5'd7;
  localparam logic [4:0] S_ESC   = 5'd8;
  localparam logic [4:0] S_SM    = 5'd9;
  localparam logic [4:0] S_SPREP = 5'd10;
  localparam logic [4:0] S_SWAIT = 5'd11;
  localparam logic [4:0] S_FIN   = 5'd12;
  localparam logic [4:0] S_FWAIT = 5'd13;
  localparam logic [4:0] S_HF    = 5'd14;
  localparam logic [4:0] S_HC    = 5'd15;
  localparam logic [4:0] S_L1    = 5'd16;
  localparam logic [4:0] S_L2    = 5'd17;
  localparam logic [4:0] S_L3    = 5'd18;
  localparam logic [4:0] S_NONE  = 5'd19;
  localparam logic [4:0] S_RMUL  = 5'd20;
  localparam logic [4:0] S_RES   = 5'd21;

  logic [4:0]  state_r, state_nxt;
  chsgeo_pkg::job_t job_r;
  logic [chsgeo_pkg::CNT_W-1:0] idx_r, idx_nxt;
  logic        k_r, k_nxt, chk_r, chk_nxt;
  logic [31:0] a_r, a_nxt, b_r, b_nxt, c_r, c_nxt, d_r, d_nxt;
  logic [31:0] cs_r, cs_nxt, ns_r, ns_nxt, hh_r, hh_nxt, ss_r, ss_nxt;
  logic        fnd_r, fnd_nxt, meth_r, meth_nxt;
  logic        ov_r;
  logic [31:0] oh_r, os_r, ocb_r;
  logic        of_r, om_r;
  logic [31:0] mx, my;
  logic [63:0] mfull;
  logic [31:0] mp;
  logic        dstart, ddone;
  logic [31:0] da, db, dq, dr;
  chsgeo_pkg::entry_t cur;
  logic [31:0] endblk, above, below, lin;
  logic        last_idx, emit;

  chsgeo_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (dstart),
    .dividend (da),
    .divisor  (db),
    .done     (ddone),
    .quo      (dq),
    .rem      (dr)
  );

  assign mfull    = mx * my;
  assign mp       = mfull[31:0];
  assign cur      = job_r.ent[idx_r[chsgeo_pkg::IDX_W-1:0]];
  assign endblk   = cur.offset + cur.size - 32'd1;
  assign last_idx = (idx_r >= job_r.count);
  assign emit     = (state_r == S_RES) && (!ov_r || !out_stall);
  assign q_pop    = (state_r == S_IDLE) && !q_empty;

  assign out_valid             = ov_r;
  assign out_found             = of_r;
  assign out_method_used       = om_r;
  assign out_heads             = oh_r;
  assign out_sectors_per_track = os_r;
  assign out_cylinder_blocks   = ocb_r;

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    k_nxt     = k_r;
    chk_nxt   = chk_r;
    a_nxt     = a_r;
    b_nxt     = b_r;
    c_nxt     = c_r;
    d_nxt     = d_r;
    cs_nxt    = cs_r;
    ns_nxt    = ns_r;
    hh_nxt    = hh_r;
    ss_nxt    = ss_r;
    fnd_nxt   = fnd_r;
    meth_nxt  = meth_r;
    mx        = '0;
    my        = '0;
    dstart    = 1'b0;
    da        = '0;
    db        = '0;
    above     = '0;
    below     = '0;
    lin       = '0;
    case (state_r)
      S_IDLE: begin
        if (!q_empty) begin
          idx_nxt   = '0;
          state_nxt = S_ECS;
        end
      end
      S_ECS: begin
        if (last_idx) begin
          idx_nxt   = '0;
          state_nxt = S_HF;
        end else if (cur.size == '0) begin
          idx_nxt = idx_r + 1'b1;
        end else begin
          state_nxt = S_CM0;
        end
      end
      S_CM0: begin
        mx = cur.offset - chsgeo_pkg::t_sect(cur.chs, 1'b0) + 32'd1;
        my = chsgeo_pkg::t_head(cur.chs, 1'b1);
        a_nxt = mp;
        state_nxt = S_CM1;
      end
      S_CM1: begin
        mx = endblk - chsgeo_pkg::t_sect(cur.chs, 1'b1) + 32'd1;
        my = chsgeo_pkg::t_head(cur.chs, 1'b0);
        b_nxt = mp;
        state_nxt = S_CM2;
      end
      S_CM2: begin
        mx = chsgeo_pkg::t_head(cur.chs, 1'b1);
        my = chsgeo_pkg::t_cyl(cur.chs, 1'b0);
        c_nxt = mp;
        state_nxt = S_CM3;
      end
      S_CM3: begin
        mx = chsgeo_pkg::t_head(cur.chs, 1'b0);
        my = chsgeo_pkg::t_cyl(cur.chs, 1'b1);
        d_nxt = mp;
        state_nxt = S_CPREP;
      end
      S_CPREP: begin
        above = a_r - b_r;
        below = c_r - d_r;
        if (above[31]) begin
          above = 32'd0 - above;
          below = 32'd0 - below;
        end
        if ((above == '0) || (below == '0)) begin
          idx_nxt   = idx_r + 1'b1;
          state_nxt = S_ECS;
        end else begin
          dstart    = 1'b1;
          da        = above;
          db        = below;
          state_nxt = S_CWAIT;
        end
      end
      S_CWAIT: begin
        if (ddone) begin
          if ((dr == '0) && (dq != '0) && !dq[31]) begin
            cs_nxt    = dq;
            idx_nxt   = '0;
            state_nxt = S_ESC;
          end else begin
            idx_nxt   = idx_r + 1'b1;
            state_nxt = S_ECS;
          end
        end
      end
      S_ESC: begin
        if (last_idx) begin
          idx_nxt   = '0;
          state_nxt = S_HF;
        end else if (cur.size == '0) begin
          idx_nxt = idx_r + 1'b1;
        end else begin
          k_nxt     = 1'b0;
          state_nxt = S_SM;
        end
      end
      S_SM: begin
        mx = cs_r;
        my = chsgeo_pkg::t_cyl(cur.chs, k_r);
        a_nxt = mp;
        if (chsgeo_pkg::t_head(cur.chs, k_r) == '0) begin
          if (!k_r) begin
            k_nxt = 1'b1;
          end else begin
            idx_nxt   = idx_r + 1'b1;
            state_nxt = S_ESC;
          end
        end else begin
          state_nxt = S_SPREP;
        end
      end
      S_SPREP: begin
        above = (k_r ? endblk : cur.offset) - chsgeo_pkg::t_sect(cur.chs, k_r)
                + 32'd1 - a_r;
        if (above == '0) begin
          if (!k_r) begin
            k_nxt     = 1'b1;
            state_nxt = S_SM;
          end else begin
            idx_nxt   = idx_r + 1'b1;
            state_nxt = S_ESC;
          end
        end else begin
          dstart    = 1'b1;
          da        = above;
          db        = chsgeo_pkg::t_head(cur.chs, k_r);
          state_nxt = S_SWAIT;
        end
      end
      S_SWAIT: begin
        if (ddone) begin
          if ((dr == '0) && (dq != '0) && !dq[31]) begin
            ns_nxt    = dq;
            state_nxt = S_FIN;
          end else if (!k_r) begin
            k_nxt     = 1'b1;
            state_nxt = S_SM;
          end else begin
            idx_nxt   = idx_r + 1'b1;
            state_nxt = S_ESC;
          end
        end
      end
      S_FIN: begin
        dstart    = 1'b1;
        da        = cs_r;
        db        = ns_r;
        state_nxt = S_FWAIT;
      end
      S_FWAIT: begin
        if (ddone) begin
          if (dr == '0) begin
            hh_nxt    = dq;
            ss_nxt    = ns_r;
            fnd_nxt   = 1'b1;
            meth_nxt  = 1'b0;
            state_nxt = S_RMUL;
          end else begin
            idx_nxt   = '0;
            state_nxt = S_HF;
          end
        end
      end
      S_HF: begin
        chk_nxt = 1'b0;
        if (last_idx) begin
          state_nxt = S_NONE;
        end else if (cur.size == '0) begin
          idx_nxt = idx_r + 1'b1;
        end else begin
          ss_nxt    = chsgeo_pkg::t_sect(cur.chs, 1'b1);
          hh_nxt    = chsgeo_pkg::t_head(cur.chs, 1'b1) + 32'd1;
          k_nxt     = 1'b0;
          state_nxt = S_L1;
        end
      end
      S_HC: begin
        chk_nxt = 1'b1;
        if (last_idx) begin
          fnd_nxt   = 1'b1;
          meth_nxt  = 1'b1;
          state_nxt = S_RMUL;
        end else if ((cur.size == '0) ||
                     (chsgeo_pkg::t_cylb(cur.chs, 1'b0) >
                      chsgeo_pkg::t_cylb(cur.chs, 1'b1))) begin
          idx_nxt = idx_r + 1'b1;
        end else begin
          k_nxt     = 1'b0;
          state_nxt = S_L1;
        end
      end
      S_L1: begin
        mx = hh_r;
        my = chsgeo_pkg::t_cyl(cur.chs, k_r);
        a_nxt = mp;
        state_nxt = S_L2;
      end
      S_L2: begin
        mx = a_r + chsgeo_pkg::t_head(cur.chs, k_r);
        my = ss_r;
        a_nxt = mp;
        state_nxt = S_L3;
      end
      S_L3: begin
        lin = a_r + chsgeo_pkg::t_sect(cur.chs, k_r) - 32'd1;
        if (k_r ? ((lin + 32'd1) == (cur.offset + cur.size)) : (lin == cur.offset)) begin
          if (!k_r) begin
            k_nxt     = 1'b1;
            state_nxt = S_L1;
          end else if (!chk_r) begin
            idx_nxt   = '0;
            state_nxt = S_HC;
          end else begin
            idx_nxt   = idx_r + 1'b1;
            state_nxt = S_HC;
          end
        end else if (chk_r) begin
          state_nxt = S_NONE;
        end else begin
          idx_nxt   = idx_r + 1'b1;
          state_nxt = S_HF;
        end
      end
      S_NONE: begin
        fnd_nxt   = 1'b0;
        meth_nxt  = 1'b0;
        hh_nxt    = '0;
        ss_nxt    = '0;
        state_nxt = S_RMUL;
      end
      S_RMUL: begin
        mx = hh_r;
        my = ss_r;
        b_nxt = mp;
        state_nxt = S_RES;
      end
      S_RES: begin
        if (emit) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      job_r <= q_data;
    end
    a_r    <= a_nxt;
    b_r    <= b_nxt;
    c_r    <= c_nxt;
    d_r    <= d_nxt;
    cs_r   <= cs_nxt;
    ns_r   <= ns_nxt;
    hh_r   <= hh_nxt;
    ss_r   <= ss_nxt;
    fnd_r  <= fnd_nxt;
    meth_r <= meth_nxt;
    idx_r  <= idx_nxt;
    k_r    <= k_nxt;
    chk_r  <= chk_nxt;
    if (emit) begin
      of_r  <= fnd_r;
      om_r  <= meth_r;
      oh_r  <= hh_r;
      os_r  <= ss_r;
      ocb_r <= b_r;
    end
    if (!rst_n) begin
      state_r <= S_IDLE;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (emit) begin
        ov_r <= 1'b1;
      end else if (!out_stall) begin
        ov_r <= 1'b0;
      end
    end
  end

endmodule

// ===== verif/tb_chs_geometry_inference.sv =====
// Testbench for chs_geometry_inference: drives partition table entries and
// checks each geometry answer against a predictor kept in a scoreboard class.
// Depends on chsgeo_pkg and the chs_geometry_inference RTL.
module tb_chs_geometry_inference;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [7:0]  sh, ssb, scl, eh, esb, ecl;
    logic [31:0] off, size;
    logic        last;
  } part_entry_t;

  typedef struct {
    logic        found, method;
    logic [31:0] heads, spt, cylb;
  } geometry_t;

  int mismatches = 0;

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] exp);
    $display("mismatch %s: got %0h expected %0h at %0t", what, got, exp, $realtime);
    mismatches++;
  endtask

  class geometry_scoreboard;
    part_entry_t table_q[chsgeo_pkg::TABLE_ENTRIES];
    int          loaded = 0;
    geometry_t   pending[$];
    int          answers = 0, found_eq = 0, found_heur = 0;

    function logic [31:0] head(int e, bit fin);
      return {24'd0, fin ? table_q[e].eh : table_q[e].sh};
    endfunction
    function logic [31:0] sect(int e, bit fin);
      return {24'd0, (fin ? table_q[e].esb : table_q[e].ssb) & 8'h3F};
    endfunction
    function logic [31:0] cylb(int e, bit fin);
      return {24'd0, fin ? table_q[e].ecl : table_q[e].scl};
    endfunction
    function logic [31:0] cyl(int e, bit fin);
      logic [7:0] b;
      b = fin ? table_q[e].esb : table_q[e].ssb;
      return cylb(e, fin) | {22'd0, b[7:6], 8'd0};
    endfunction
    function bit positive(logic [31:0] v);
      return v != 0 && !v[31];
    endfunction

    function bit cylinder_size(int e, output logic [31:0] cs);
      logic [31:0] sb, eb, above, below;
      sb = table_q[e].off;
      eb = sb + table_q[e].size - 1;
      above = (sb - sect(e, 0) + 1) * head(e, 1) - (eb - sect(e, 1) + 1) * head(e, 0);
      below = head(e, 1) * cyl(e, 0) - head(e, 0) * cyl(e, 1);
      cs = 0;
      if (above[31]) begin
        above = -above;
        below = -below;
      end
      if (above == 0 || below == 0) return 0;
      if (above % below != 0) return 0;
      cs = above / below;
      return positive(cs);
    endfunction

    function bit sector_count(logic [31:0] cs, logic [31:0] bno, int e, bit fin,
                              output logic [31:0] ns);
      logic [31:0] above, below;
      ns = 0;
      below = head(e, fin);
      if (below == 0) return 0;
      above = bno - sect(e, fin) + 1 - cs * cyl(e, fin);
      if (above == 0 || above % below != 0) return 0;
      ns = above / below;
      return positive(ns);
    endfunction

    function logic [31:0] to_linear(int e, bit fin, logic [31:0] h, logic [31:0] s);
      logic [31:0] b;
      b = (h * cyl(e, fin) + head(e, fin)) * s;
      return b + sect(e, fin) - 1;
    endfunction

    function bit by_equations(int n, output logic [31:0] h, output logic [31:0] s);
      logic [31:0] cs, ns;
      bit ok;
      ok = 0; cs = 0; ns = 0; h = 0; s = 0;
      for (int e = 0; e < n && !ok; e++)
        if (table_q[e].size != 0) ok = cylinder_size(e, cs);
      if (!ok) return 0;
      ok = 0;
      for (int e = 0; e < n && !ok; e++) begin
        if (table_q[e].size == 0) continue;
        ok = sector_count(cs, table_q[e].off, e, 0, ns);
        if (!ok)
          ok = sector_count(cs, table_q[e].off + table_q[e].size - 1, e, 1, ns);
      end
      if (!ok || cs % ns != 0) return 0;
      h = cs / ns;
      s = ns;
      return 1;
    endfunction

    function bit by_cylinder_end(int n, output logic [31:0] h, output logic [31:0] s);
      logic [31:0] hh, ss;
      bit ok;
      ok = 0; hh = 0; ss = 0; h = 0; s = 0;
      for (int e = 0; e < n && !ok; e++) begin
        if (table_q[e].size == 0) continue;
        ss = sect(e, 1);
        hh = head(e, 1) + 1;
        if (to_linear(e, 0, hh, ss) != table_q[e].off) continue;
        if (to_linear(e, 1, hh, ss) + 1 == table_q[e].off + table_q[e].size) ok = 1;
      end
      if (!ok) return 0;
      for (int e = 0; e < n; e++) begin
        if (table_q[e].size == 0 || cylb(e, 0) > cylb(e, 1)) continue;
        if (to_linear(e, 0, hh, ss) != table_q[e].off) return 0;
        if (to_linear(e, 1, hh, ss) + 1 != table_q[e].off + table_q[e].size) return 0;
      end
      h = hh;
      s = ss;
      return 1;
    endfunction

    function void note_entry(part_entry_t it);
      geometry_t g;
      logic [31:0] h, s;
      int n;
      if (loaded < chsgeo_pkg::TABLE_ENTRIES) table_q[loaded++] = it;
      if (!it.last) return;
      n = loaded;
      loaded = 0;
      g = '{default: 0};
      if (by_equations(n, h, s)) begin
        g.found = 1; g.method = 0;
      end else if (by_cylinder_end(n, h, s)) begin
        g.found = 1; g.method = 1;
      end else begin
        h = 0; s = 0;
      end
      g.heads = h;
      g.spt = s;
      g.cylb = h * s;
      pending.push_back(g);
    endfunction

    task check_answer(geometry_t got);
      geometry_t exp;
      if (pending.size() == 0) begin
        report("unexpected result", 32'd0, 32'd0);
        return;
      end
      exp = pending.pop_front();
      answers++;
      if (got.found) begin
        if (got.method) found_heur++;
        else found_eq++;
      end
      if (got.found !== exp.found)
        report("found", {31'd0, got.found}, {31'd0, exp.found});
      if (got.method !== exp.method)
        report("method_used", {31'd0, got.method}, {31'd0, exp.method});
      if (got.heads !== exp.heads) report("heads", got.heads, exp.heads);
      if (got.spt !== exp.spt) report("sectors_per_track", got.spt, exp.spt);
      if (got.cylb !== exp.cylb) report("cylinder_blocks", got.cylb, exp.cylb);
    endtask
  endclass

  logic clk = 0, rst_n = 0;
  logic in_valid = 0, in_stall, in_last_entry = 0;
  logic [7:0] in_start_head = 0, in_start_sector_byte = 0, in_start_cyl_low = 0;
  logic [7:0] in_end_head = 0, in_end_sector_byte = 0, in_end_cyl_low = 0;
  logic [31:0] in_lba_offset = 0, in_lba_size = 0;
  logic out_valid, out_stall = 0, out_found, out_method_used;
  logic [31:0] out_heads, out_sectors_per_track, out_cylinder_blocks;

  chs_geometry_inference dut (.*);

  always begin
    #4 clk = 1;
    #4 clk = 0;
  end

  geometry_scoreboard sb = new();
  bit quiet = 0;
  int idle_cycles = 0;
  int beats_in = 0;

  task automatic send_entry(part_entry_t it);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    in_valid <= 1;
    in_start_head <= it.sh; in_start_sector_byte <= it.ssb; in_start_cyl_low <= it.scl;
    in_end_head <= it.eh; in_end_sector_byte <= it.esb; in_end_cyl_low <= it.ecl;
    in_lba_offset <= it.off; in_lba_size <= it.size; in_last_entry <= it.last;
    do @(posedge clk); while (in_stall);
    sb.note_entry(it);
    beats_in++;
  endtask

  // Builds an entry that is consistent with the given geometry.
  function automatic part_entry_t make_entry(int h, int s, int c0, int c1, bit last);
    part_entry_t it;
    logic [31:0] lba0, lba1;
    lba0 = (c0 * h + (c0 == 0 ? 1 : 0)) * s;
    lba1 = (c1 * h + h - 1) * s + s - 1;
    it.sh = (c0 == 0) ? 8'd1 : 8'd0;
    it.ssb = {c0[9:8], 6'd1};
    it.scl = c0[7:0];
    it.eh = 8'(h - 1);
    it.esb = {c1[9:8], s[5:0]};
    it.ecl = c1[7:0];
    it.off = lba0;
    it.size = lba1 - lba0 + 1;
    it.last = last;
    return it;
  endfunction

  function automatic part_entry_t noise_entry(bit last);
    part_entry_t it;
    it.sh = 8'($urandom); it.ssb = 8'($urandom); it.scl = 8'($urandom);
    it.eh = 8'($urandom); it.esb = 8'($urandom); it.ecl = 8'($urandom);
    it.off = $urandom; it.size = $urandom_range(0, 3) == 0 ? 0 : $urandom;
    it.last = last;
    return it;
  endfunction

  task automatic send_table(bit wellformed);
    int n, h, s, c;
    part_entry_t it;
    n = $urandom_range(0, 9) == 0 ? $urandom_range(5, 6) : $urandom_range(1, 4);
    h = $urandom_range(0, 3) == 0 ? $urandom_range(1, 256) : ($urandom_range(0, 1) ? 255 : 16);
    s = $urandom_range(0, 3) == 0 ? $urandom_range(1, 63) : 63;
    c = $urandom_range(0, 20);
    for (int i = 0; i < n; i++) begin
      if (wellformed && $urandom_range(0, 7) != 0) begin
        it = make_entry(h, s, c, c + $urandom_range(0, 40), i == n - 1);
        c = c + 41 + $urandom_range(0, 200);
        if (c > 1000) c = $urandom_range(0, 20);
        if ($urandom_range(0, 9) == 0) it.size = 0;
        if ($urandom_range(0, 12) == 0) it.off ^= 1 << $urandom_range(0, 31);
      end else
        it = noise_entry(i == n - 1);
      send_entry(it);
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_answer('{out_found, out_method_used, out_heads, out_sectors_per_track,
                        out_cylinder_blocks});
  end

  initial begin
    forever begin
      @(posedge clk);
      if (quiet) out_stall <= 0;
      else if ($urandom_range(0, 7) == 0) begin
        out_stall <= 1;
        repeat ($urandom_range(1, 14)) @(posedge clk);
        out_stall <= 0;
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 20000) begin
      $display("tb_chs_geometry_inference failed");
      $finish;
    end
  end

  initial begin
    part_entry_t it;
    repeat (3) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    // Directed: extremes, empty entries, overflow, both methods.
    it = '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1};
    send_entry(it);
    it = '{default: '0};
    it.last = 1'b1;
    send_entry(it);
    send_entry(make_entry(255, 63, 0, 100, 0));
    send_entry(make_entry(255, 63, 101, 500, 0));
    send_entry(make_entry(255, 63, 501, 1023, 1));
    send_entry(make_entry(16, 63, 1, 1, 1));
    send_entry(make_entry(16, 63, 5, 9, 0));
    it = make_entry(16, 63, 20, 10, 1);
    send_entry(it);
    for (int i = 0; i < 6; i++) send_entry(make_entry(240, 63, i * 50, i * 50 + 40, i == 5));
    send_entry(make_entry(1, 1, 3, 700, 1));
    send_entry(make_entry(256, 63, 10, 20, 1));
    send_entry(noise_entry(0));
    send_entry(noise_entry(1));
    while (beats_in < 430) send_table($urandom_range(0, 4) != 0);
    quiet = 1;
    while (beats_in < 460) send_table(1);
    in_valid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (500) @(posedge clk);
    $display("Sent %0d entries; %0d answers checked, %0d by equations, %0d by cylinder end.",
             beats_in, sb.answers, sb.found_eq, sb.found_heur);
    if (mismatches == 0 && sb.pending.size() == 0)
      $display("tb_chs_geometry_inference passed");
    else
      $display("tb_chs_geometry_inference failed");
    $finish;
  end
endmodule
